[rtl/psq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_pkg: shared types for the sorted priority stack
// Command and status codes, and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package psq_pkg;

    // operation codes on cmd; the unused code acts as a query
    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_POP   = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // per-cycle control shared by all cells
    typedef struct packed {
        logic push;   // insert new entry, shift lower entries down
        logic pop;    // drop top entry, shift all entries up
    } cell_ctrl_t;

endpackage

[rtl/psq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_cell: one slot of the sorted priority stack
// Holds one entry, compares it against the pushed priority and takes its
// data from itself, its upper or lower neighbour, or the new entry.
// ----------------------------------------------------------------------------
module psq_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int PRIO_WIDTH  = 16
) (
    input  logic                   clk,
    input  psq_pkg::cell_ctrl_t    ctrl,
    input  logic                   occupied,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [PRIO_WIDTH-1:0]  new_priority,
    input  logic                   up_keep,
    input  logic [VALUE_WIDTH-1:0] up_value,
    input  logic [PRIO_WIDTH-1:0]  up_priority,
    input  logic [VALUE_WIDTH-1:0] down_value,
    input  logic [PRIO_WIDTH-1:0]  down_priority,
    output logic                   keep,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [PRIO_WIDTH-1:0]  priority_q
);
    import psq_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [PRIO_WIDTH-1:0]  prio_reg, prio_next;

    // entry stays put on a push when it outranks the new one
    assign keep = occupied && (prio_reg > new_priority);

    // next entry: hold, insert, shift down on push, shift up on pop
    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.push && !keep)
        begin
            if (up_keep)
            begin
                value_next = new_value;
                prio_next  = new_priority;
            end
            else
            begin
                value_next = up_value;
                prio_next  = up_priority;
            end
        end
        else if (ctrl.pop)
        begin
            value_next = down_value;
            prio_next  = down_priority;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value      = value_reg;
    assign priority_q = prio_reg;

endmodule

[rtl/priority_stack_sorted_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_stack_sorted_insert: bounded priority stack, sorted on insert
// A row of DEPTH cells keeps entries sorted, highest priority at cell 0;
// ties leave last-in first-out. Push, pop or query one beat per cycle.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   command  | start / busy         | cmd, push_value, push_priority
//   result   | done (1-cycle pulse) | top_value, top_priority, entry_count,
//            |                      | is_empty, status
//
// A command beat is taken at any edge with start high; busy stays low.
// Every cell compares and shifts in the same cycle, so the result of each beat
// shows in the cycle after, for exactly one cycle.
// Reset empties the stack at once; the cells hold no reset value.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module priority_stack_sorted_insert #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int PRIO_WIDTH  = 16,
    parameter int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             cmd,
    input  logic [VALUE_WIDTH-1:0] push_value,
    input  logic [PRIO_WIDTH-1:0]  push_priority,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] top_value,
    output logic [PRIO_WIDTH-1:0]  top_priority,
    output logic [CNT_W-1:0]       entry_count,
    output logic                   is_empty,
    output logic [1:0]             status
);
    import psq_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    status_t          status_reg, status_next;
    cell_ctrl_t       ctrl;

    logic [DEPTH-1:0]       keep;
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [PRIO_WIDTH-1:0]  cell_prio  [DEPTH];

    // command decode and occupancy update
    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = STAT_OK;
        if (start)
        begin
            unique case (cmd)
                CMD_PUSH:
                begin
                    if (count_reg == FULL_CNT)
                        status_next = STAT_FULL;
                    else
                    begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    if (count_reg == '0)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    // row of cells, cell 0 is the top
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                   up_keep;
        logic [VALUE_WIDTH-1:0] up_value, down_value;
        logic [PRIO_WIDTH-1:0]  up_prio, down_prio;

        if (i == 0)
        begin : g_top
            assign up_keep  = 1'b1;
            assign up_value = push_value;
            assign up_prio  = push_priority;
        end
        else
        begin : g_mid
            assign up_keep  = keep[i-1];
            assign up_value = cell_value[i-1];
            assign up_prio  = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bot
            assign down_value = cell_value[i];
            assign down_prio  = cell_prio[i];
        end
        else
        begin : g_low
            assign down_value = cell_value[i+1];
            assign down_prio  = cell_prio[i+1];
        end

        psq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .PRIO_WIDTH  (PRIO_WIDTH)
        ) u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .occupied      (CNT_W'(i) < count_reg),
            .new_value     (push_value),
            .new_priority  (push_priority),
            .up_keep       (up_keep),
            .up_value      (up_value),
            .up_priority   (up_prio),
            .down_value    (down_value),
            .down_priority (down_prio),
            .keep          (keep[i]),
            .value         (cell_value[i]),
            .priority_q    (cell_prio[i])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    // status of the last beat
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    // result read straight from the top cell after the update
    assign busy         = 1'b0;
    assign done         = done_reg;
    assign is_empty     = (count_reg == '0);
    assign top_value    = is_empty ? '0 : cell_value[0];
    assign top_priority = is_empty ? '0 : cell_prio[0];
    assign entry_count  = count_reg;
    assign status       = status_reg;

endmodule

[rtl/psq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_checker: port-level checks for the sorted priority stack
// Watches command and result beats and the consistency of the result fields.
// ----------------------------------------------------------------------------
module psq_checker #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int PRIO_WIDTH  = 16,
    parameter int CNT_W       = $clog2(DEPTH + 1)
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input logic [VALUE_WIDTH-1:0] top_value,
    input logic [PRIO_WIDTH-1:0]  top_priority,
    input logic [CNT_W-1:0]       entry_count,
    input logic                   is_empty,
    input logic [1:0]             status
);
    import psq_pkg::*;

    // every command beat gives exactly one result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("command beat without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without command beat");

    // empty flag, count and top fields agree
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> (entry_count == '0 && top_value == '0
                                && top_priority == '0))
        else $error("empty result with nonzero fields");

    // drop codes only at the bounds
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status != STAT_FULL || entry_count == CNT_W'(DEPTH))
                  && (status != STAT_EMPTY || is_empty)))
        else $error("status inconsistent with count");

    // count never exceeds the depth, and the empty flag matches a zero count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entry_count <= CNT_W'(DEPTH)
                  && is_empty == (entry_count == '0)))
        else $error("entry count out of range");

endmodule

bind priority_stack_sorted_insert psq_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .PRIO_WIDTH  (PRIO_WIDTH),
    .CNT_W       (CNT_W)
) u_psq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .top_value    (top_value),
    .top_priority (top_priority),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .status       (status)
);
